// ===== rtl/core/mfre_pkg.sv =====
// Shared widths, codes and types of the matrix flip/rotate engine.
package mfre_pkg;

    localparam int MAX_DIM     = 128;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int PROD_W      = 2 * DIM_W;
    localparam int DATA_W      = 32;
    localparam int KIND_W      = 2;
    localparam int OP_W        = 3;
    localparam int CFG_W       = 8;
    localparam int CFG_IDX_W   = 1;

    localparam logic [DIM_W-1:0] ROWS_RESET = DIM_W'(4);
    localparam logic [DIM_W-1:0] COLS_RESET = DIM_W'(4);

    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OP   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

    localparam logic [OP_W-1:0] OP_VFLIP = 3'd0;
    localparam logic [OP_W-1:0] OP_HFLIP = 3'd1;
    localparam logic [OP_W-1:0] OP_RCW   = 3'd2;
    localparam logic [OP_W-1:0] OP_RCCW  = 3'd3;
    localparam logic [OP_W-1:0] OP_QCW   = 3'd4;
    localparam logic [OP_W-1:0] OP_QCCW  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic              rd_en;
        logic              rd_bank;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic              wr_bank;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
    } mem_req_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              done;
    } walk_t;

endpackage

// ===== rtl/core/mfre_if.sv =====
// Valid/ready channel interfaces of the matrix flip/rotate engine.
interface mfre_req_if
    import mfre_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] pixel_value;
    logic [OP_W-1:0]          op_code;

    modport source (output valid, kind, pixel_value, op_code, input ready);
    modport sink (input valid, kind, pixel_value, op_code, output ready);
endinterface

interface mfre_rsp_if
    import mfre_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] pixel_out;
    logic                     last_pixel;

    modport source (output valid, pixel_out, last_pixel, input ready);
    modport sink (input valid, pixel_out, last_pixel, output ready);
endinterface

// ===== rtl/core/matrix_flip_rotate_engine_core.sv =====
// Top level of the matrix flip/rotate engine: control, config and output register.
//
// Usage:
//   req  (valid/ready): one item per transfer. kind selects load element,
//        apply operation or read next element; pixel_value and op_code
//        carry the payload for load and operation items.
//   rsp  (valid/ready): one transfer per read item, pixel_out plus
//        last_pixel on the final element of the current frame.
//   cfg_we/cfg_index/cfg_data: write frame_rows (index 0) or frame_cols
//        (index 1), clamped to 2..MAX_DIM; a write starts a new frame.
// Timing:
//   Load item: written into the current bank; the next item can follow at
//   once. Read item: the frame memory registers the read data, which then
//   moves into the rsp register; no new item is taken meanwhile. Operation
//   item: the walker moves one element per cycle from the current bank to
//   the other bank through its single read port, then the banks swap roles.
// Reset: 4x4 frame, load and read positions at zero; memory contents are
//   undefined until loaded, and no clearing pass runs.
// Stall: a waiting result holds in the rsp register; loads and operations
//   are still taken; a further read's data waits until the register frees up.
module matrix_flip_rotate_engine_core
    import mfre_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    mfre_req_if.sink             req,
    mfre_rsp_if.source           rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    state_t            state_reg, state_next;
    logic              bank_reg, bank_next;
    logic [DIM_W-1:0]  frame_rows_reg, frame_rows_next;
    logic [DIM_W-1:0]  frame_cols_reg, frame_cols_next;
    logic [DIM_W-1:0]  cur_rows_reg, cur_rows_next;
    logic [DIM_W-1:0]  cur_cols_reg, cur_cols_next;
    logic [CNT_W-1:0]  load_index_reg, load_index_next;
    logic [CNT_W-1:0]  read_index_reg, read_index_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic              last_reg, last_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;

    logic [PROD_W-1:0] dim_prod;
    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  rd_idx;
    logic [CNT_W-1:0]  rd_inc;
    logic              walk_start;
    walk_t             walk;
    mem_req_t          mem;
    logic [DATA_W-1:0] rdata;

    // Saturate a register write into the legal dimension range.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (int'(v) < 2)
        begin
            r = DIM_W'(2);
        end
        else if (int'(v) > MAX_DIM)
        begin
            r = DIM_W'(MAX_DIM);
        end
        else
        begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

    assign dim_prod = {DIM_W'(0), cur_rows_reg} * {DIM_W'(0), cur_cols_reg};
    assign total    = dim_prod[CNT_W-1:0];

    // Wrap the read position if the frame shrank under it.
    assign rd_idx = (read_index_reg >= total) ? '0 : read_index_reg;
    assign rd_inc = rd_idx + CNT_W'(1);

    mfre_walker u_walker (
        .clk   (clk),
        .rst_n (rst_n),
        .start (walk_start),
        .op    (op_reg),
        .rows  (cur_rows_reg),
        .cols  (cur_cols_reg),
        .walk  (walk)
    );

    mfre_store u_store (
        .clk   (clk),
        .mem   (mem),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        bank_next       = bank_reg;
        frame_rows_next = frame_rows_reg;
        frame_cols_next = frame_cols_reg;
        cur_rows_next   = cur_rows_reg;
        cur_cols_next   = cur_cols_reg;
        load_index_next = load_index_reg;
        read_index_next = read_index_reg;
        op_next         = op_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        walk_start      = 1'b0;
        req.ready       = 1'b0;

        mem.rd_en   = 1'b0;
        mem.rd_bank = bank_reg;
        mem.rd_addr = rd_idx[ADDR_W-1:0];
        mem.wr_en   = 1'b0;
        mem.wr_bank = bank_reg;
        mem.wr_addr = load_index_reg[ADDR_W-1:0];
        mem.wr_data = req.pixel_value;

        // Free the output register on a completed transfer.
        if (rsp.ready && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    unique case (req.kind)
                        KIND_LOAD:
                        begin
                            // Drop loads past the end of the frame.
                            if (load_index_reg < total)
                            begin
                                mem.wr_en       = 1'b1;
                                load_index_next = load_index_reg + CNT_W'(1);
                            end
                        end
                        KIND_OP:
                        begin
                            if (req.op_code <= OP_QCCW)
                            begin
                                if ((req.op_code == OP_QCW || req.op_code == OP_QCCW)
                                    && (cur_rows_reg[0] || cur_cols_reg[0]))
                                begin
                                    // Odd dimension: quadrant move is a no-op.
                                    read_index_next = '0;
                                end
                                else
                                begin
                                    op_next    = req.op_code;
                                    walk_start = 1'b1;
                                    state_next = ST_RUN;
                                end
                            end
                        end
                        KIND_READ:
                        begin
                            mem.rd_en       = 1'b1;
                            last_next       = rd_inc == total;
                            read_index_next = (rd_inc >= total) ? '0 : rd_inc;
                            state_next      = ST_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // Hold the read data until the output register is free.
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = rdata;
                    out_last_next  = last_reg;
                    state_next     = ST_IDLE;
                end
            end
            ST_RUN:
            begin
                // Stream the current bank into the other bank.
                mem.rd_en   = walk.rd_en;
                mem.rd_addr = walk.rd_addr;
                mem.wr_en   = walk.wr_en;
                mem.wr_bank = !bank_reg;
                mem.wr_addr = walk.wr_addr;
                mem.wr_data = rdata;
                if (walk.done)
                begin
                    bank_next       = !bank_reg;
                    read_index_next = '0;
                    if (op_reg == OP_RCW || op_reg == OP_RCCW)
                    begin
                        cur_rows_next = cur_cols_reg;
                        cur_cols_next = cur_rows_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Register write starts a new frame at the written dimensions.
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROWS: frame_rows_next = clamp_dim(cfg_data);
                REG_COLS: frame_cols_next = clamp_dim(cfg_data);
                default:
                begin
                end
            endcase
            cur_rows_next   = frame_rows_next;
            cur_cols_next   = frame_cols_next;
            load_index_next = '0;
            read_index_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            bank_reg       <= 1'b0;
            frame_rows_reg <= ROWS_RESET;
            frame_cols_reg <= COLS_RESET;
            cur_rows_reg   <= ROWS_RESET;
            cur_cols_reg   <= COLS_RESET;
            load_index_reg <= '0;
            read_index_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bank_reg       <= bank_next;
            frame_rows_reg <= frame_rows_next;
            frame_cols_reg <= frame_cols_next;
            cur_rows_reg   <= cur_rows_next;
            cur_cols_reg   <= cur_cols_next;
            load_index_reg <= load_index_next;
            read_index_reg <= read_index_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.pixel_out  = out_data_reg;
    assign rsp.last_pixel = out_last_reg;

    // A transform never reads and writes the same bank in one cycle.
    a_bank_split: assert property (@(posedge clk) disable iff (!rst_n)
        (mem.rd_en && mem.wr_en) |-> (mem.rd_bank != mem.wr_bank))
        else $error("frame read and write hit the same bank");

    // Finishing a transform swaps the banks.
    a_bank_swap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && walk.done) |=> (bank_reg != $past(bank_reg)))
        else $error("bank not swapped after transform");

    // The load position never runs past the frame.
    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        load_index_reg <= total)
        else $error("load position beyond frame");

    // The walker runs only while the control sits in the transform state.
    a_walk_state: assert property (@(posedge clk) disable iff (!rst_n)
        (walk.rd_en || walk.wr_en) |-> (state_reg == ST_RUN))
        else $error("walker active outside transform");

endmodule

// ===== rtl/core/mfre_store.sv =====
// Ping-pong frame memories: two banks, one read and one write per cycle.
module mfre_store
    import mfre_pkg::*;
(
    input  logic              clk,
    input  mem_req_t          mem,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] bank0 [STORE_DEPTH];
    logic [DATA_W-1:0] bank1 [STORE_DEPTH];
    logic [DATA_W-1:0] rdata0_reg;
    logic [DATA_W-1:0] rdata1_reg;
    logic              rd_bank_reg;

    always_ff @(posedge clk)
    begin
        if (mem.wr_en && !mem.wr_bank)
        begin
            bank0[mem.wr_addr] <= mem.wr_data;
        end
        if (mem.rd_en && !mem.rd_bank)
        begin
            rdata0_reg <= bank0[mem.rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem.wr_en && mem.wr_bank)
        begin
            bank1[mem.wr_addr] <= mem.wr_data;
        end
        if (mem.rd_en && mem.rd_bank)
        begin
            rdata1_reg <= bank1[mem.rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem.rd_en)
        begin
            rd_bank_reg <= mem.rd_bank;
        end
    end

    assign rdata = rd_bank_reg ? rdata1_reg : rdata0_reg;

endmodule

// ===== rtl/core/mfre_walker.sv =====
// Frame walker: scans source addresses and computes each element's destination.
module mfre_walker
    import mfre_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [OP_W-1:0]  op,
    input  logic [DIM_W-1:0] rows,
    input  logic [DIM_W-1:0] cols,
    output walk_t            walk
);

    logic              run_reg;
    logic              wr_pend_reg;
    logic [DIM_W-1:0]  row_reg;
    logic [DIM_W-1:0]  col_reg;
    logic [ADDR_W-1:0] src_reg;
    logic [ADDR_W-1:0] dest_reg;

    logic [DIM_W-1:0]  half_rows;
    logic [DIM_W-1:0]  half_cols;
    logic              top_half;
    logic              left_half;
    logic [DIM_W-1:0]  row_term;
    logic [DIM_W-1:0]  stride;
    logic [DIM_W-1:0]  col_term;
    logic [PROD_W-1:0] dest_sum;
    logic              last_row;
    logic              last_col;

    assign half_rows = rows >> 1;
    assign half_cols = cols >> 1;
    assign top_half  = row_reg < half_rows;
    assign left_half = col_reg < half_cols;
    assign last_row  = row_reg == rows - DIM_W'(1);
    assign last_col  = col_reg == cols - DIM_W'(1);

    always_comb
    begin
        row_term = row_reg;
        stride   = cols;
        col_term = col_reg;
        unique case (op)
            OP_VFLIP:
            begin
                row_term = rows - DIM_W'(1) - row_reg;
            end
            OP_HFLIP:
            begin
                col_term = cols - DIM_W'(1) - col_reg;
            end
            OP_RCW:
            begin
                row_term = col_reg;
                stride   = rows;
                col_term = rows - DIM_W'(1) - row_reg;
            end
            OP_RCCW:
            begin
                row_term = cols - DIM_W'(1) - col_reg;
                stride   = rows;
                col_term = row_reg;
            end
            OP_QCW:
            begin
                if (top_half && left_half)
                begin
                    col_term = col_reg + half_cols;
                end
                else if (top_half)
                begin
                    row_term = row_reg + half_rows;
                end
                else if (!left_half)
                begin
                    col_term = col_reg - half_cols;
                end
                else
                begin
                    row_term = row_reg - half_rows;
                end
            end
            default:
            begin
                // counter-clockwise quadrant move
                if (top_half && left_half)
                begin
                    row_term = row_reg + half_rows;
                end
                else if (top_half)
                begin
                    col_term = col_reg - half_cols;
                end
                else if (!left_half)
                begin
                    row_term = row_reg - half_rows;
                end
                else
                begin
                    col_term = col_reg + half_cols;
                end
            end
        endcase
        dest_sum = {DIM_W'(0), row_term} * {DIM_W'(0), stride} + {DIM_W'(0), col_term};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= 1'b0;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            wr_pend_reg <= run_reg;
            if (start)
            begin
                run_reg <= 1'b1;
            end
            else if (run_reg && last_row && last_col)
            begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            row_reg <= '0;
            col_reg <= '0;
            src_reg <= '0;
        end
        else if (run_reg)
        begin
            src_reg  <= src_reg + ADDR_W'(1);
            dest_reg <= dest_sum[ADDR_W-1:0];
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= row_reg + DIM_W'(1);
            end
            else
            begin
                col_reg <= col_reg + DIM_W'(1);
            end
        end
    end

    assign walk.rd_en   = run_reg;
    assign walk.rd_addr = src_reg;
    assign walk.wr_en   = wr_pend_reg;
    assign walk.wr_addr = dest_reg;
    assign walk.done    = wr_pend_reg && !run_reg;

endmodule
